/* design/rtp_packetizer_fragmenter_top_defines.svh */
// ---------------------------------------------------------------------------
// RTP packetizer assertion macros
// Shared concurrent assertion wrappers, clocked on clk_i.
// ---------------------------------------------------------------------------
`ifndef RTP_PACKETIZER_FRAGMENTER_TOP_DEFINES_SVH
`define RTP_PACKETIZER_FRAGMENTER_TOP_DEFINES_SVH

// Assertion checked only outside reset.
`define RTPF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Assertion checked at every clock edge, reset included.
`define RTPF_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

/* design/rtpf_pkg.sv */
// ---------------------------------------------------------------------------
// RTP packetizer package
// Constants, register indexes and the job record handed to the output stage.
// ---------------------------------------------------------------------------
package rtpf_pkg;

  localparam int unsigned HdrLen = 12;
  localparam int unsigned IdxW   = $clog2(HdrLen + 1);
  localparam int unsigned CfgIdxW = 3;

  localparam logic [7:0] VersionByte = 8'h80;

  // register indexes
  localparam logic [CfgIdxW-1:0] CFG_FRAME_BYTES  = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_MAX_FRAG     = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_PAYLOAD_TYPE = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_SSRC         = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_SAMPLES      = 3'd4;

  // register reset values
  localparam logic [15:0] FrameBytesRst = 16'd2304;
  localparam logic [10:0] MaxFragRst    = 11'd1446;
  localparam logic [6:0]  PayloadTypeRst = 7'd96;
  localparam logic [31:0] SsrcRst       = 32'h1234_5678;
  localparam logic [15:0] SamplesRst    = 16'd48;

  typedef logic [IdxW-1:0] rtpf_idx_t;

  // byte position of the payload byte within one job
  localparam rtpf_idx_t PayloadIdx = IdxW'(HdrLen);

  // everything one input request causes on the output side
  typedef struct packed {
    logic [HdrLen-1:0][7:0] hdr;      // hdr[0] goes out first
    logic                   has_hdr;
    logic [7:0]             data;
    logic                   closes;
  } rtpf_job_t;

endpackage

/* design/rtp_packetizer_fragmenter_top.sv */
// ---------------------------------------------------------------------------
// RTP packetizer with fragmentation
// Wraps audio frame payload bytes into RTP datagrams of bounded size.
// ---------------------------------------------------------------------------
// Each accepted payload byte yields one output byte, or thirteen when it opens
// a fragment (the 12-byte RTP header, then the byte itself). All fragment and
// header decisions are made in the accept cycle and land in a single job
// register; the output port drains it at one byte per cycle unless stalled. A
// new request is taken in the same cycle as the previous payload byte leaves,
// so unstalled bytes inside a fragment flow at one per cycle, and a
// fragment-opening byte holds the input until its payload byte leaves. Output
// stalls aside, throughput is set by the output port's one byte per cycle.
// Register writes are taken in any cycle; the size, marker and header of a
// fragment are fixed when its first byte is accepted, a new frame size takes
// effect at the next fragment, a new samples count at the end of the frame.
// ---------------------------------------------------------------------------
`include "rtp_packetizer_fragmenter_top_defines.svh"

module rtp_packetizer_fragmenter_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration writes
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [rtpf_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [31:0]                  cfg_data_i,
  // payload input
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [7:0]                   payload_byte_i,
  // datagram output
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [7:0]                   out_byte_o,
  output logic                         datagram_first_o,
  output logic                         datagram_last_o,
  output logic                         run_last_o
);
  import rtpf_pkg::*;

  // configuration registers
  logic [15:0] frame_bytes_q;
  logic [10:0] max_frag_q;
  logic [6:0]  payload_type_q;
  logic [31:0] ssrc_q;
  logic [15:0] samples_q;

  // stream state
  logic [15:0] seq_q, seq_d;
  logic [31:0] ts_q, ts_d;
  logic [15:0] offset_q, offset_d;
  logic [10:0] count_q, count_d;
  logic [10:0] size_q, size_d;
  logic        marker_q, marker_d;

  logic        in_accept;
  logic        can_load;
  logic        opens;
  logic [15:0] fb, remaining;
  logic [10:0] mp, new_size, eff_size, count_inc;
  logic        new_marker, eff_marker, closes;
  rtpf_job_t   job;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_bytes_q  <= FrameBytesRst;
      max_frag_q     <= MaxFragRst;
      payload_type_q <= PayloadTypeRst;
      ssrc_q         <= SsrcRst;
      samples_q      <= SamplesRst;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_FRAME_BYTES:  frame_bytes_q  <= cfg_data_i[15:0];
        CFG_MAX_FRAG:     max_frag_q     <= cfg_data_i[10:0];
        CFG_PAYLOAD_TYPE: payload_type_q <= cfg_data_i[6:0];
        CFG_SSRC:         ssrc_q         <= cfg_data_i;
        CFG_SAMPLES:      samples_q      <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  assign in_stall_o = !can_load;
  assign in_accept  = in_valid_i && can_load;

  // fragment sizing when a byte opens a fragment; zero sizes act as one
  assign opens     = (count_q == '0);
  assign fb        = (frame_bytes_q == '0) ? 16'd1 : frame_bytes_q;
  assign mp        = (max_frag_q == '0) ? 11'd1 : max_frag_q;
  // frame shrunk below the offset: a one-byte closing fragment
  assign remaining = (offset_q < fb) ? (fb - offset_q) : 16'd1;
  assign new_size  = (remaining > {5'd0, mp}) ? mp : remaining[10:0];
  assign new_marker = ({5'd0, new_size} == remaining);

  assign eff_size   = opens ? new_size : size_q;
  assign eff_marker = opens ? new_marker : marker_q;
  assign count_inc  = count_q + 11'd1;
  assign closes     = (count_inc >= eff_size);

  always_comb begin
    seq_d    = seq_q;
    ts_d     = ts_q;
    offset_d = offset_q;
    count_d  = count_q;
    size_d   = size_q;
    marker_d = marker_q;
    if (in_accept) begin
      size_d   = eff_size;
      marker_d = eff_marker;
      count_d  = count_inc;
      offset_d = offset_q + 16'd1;
      if (closes) begin
        count_d = '0;
        seq_d   = seq_q + 16'd1;
        if (eff_marker) begin
          ts_d     = ts_q + {16'd0, samples_q};
          offset_d = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q    <= '0;
      ts_q     <= '0;
      offset_q <= '0;
      count_q  <= '0;
      size_q   <= '0;
      marker_q <= 1'b0;
    end else begin
      seq_q    <= seq_d;
      ts_q     <= ts_d;
      offset_q <= offset_d;
      count_q  <= count_d;
      size_q   <= size_d;
      marker_q <= marker_d;
    end
  end

  // header bytes, big-endian fields
  always_comb begin
    job.hdr[0]  = VersionByte;
    job.hdr[1]  = {new_marker, payload_type_q};
    job.hdr[2]  = seq_q[15:8];
    job.hdr[3]  = seq_q[7:0];
    job.hdr[4]  = ts_q[31:24];
    job.hdr[5]  = ts_q[23:16];
    job.hdr[6]  = ts_q[15:8];
    job.hdr[7]  = ts_q[7:0];
    job.hdr[8]  = ssrc_q[31:24];
    job.hdr[9]  = ssrc_q[23:16];
    job.hdr[10] = ssrc_q[15:8];
    job.hdr[11] = ssrc_q[7:0];
    job.has_hdr = opens;
    job.data    = payload_byte_i;
    job.closes  = closes;
  end

  rtpf_emit u_emit (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .load_i           (in_accept),
    .job_i            (job),
    .can_load_o       (can_load),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .out_byte_o       (out_byte_o),
    .datagram_first_o (datagram_first_o),
    .datagram_last_o  (datagram_last_o),
    .run_last_o       (run_last_o)
  );

  // assertions
  `RTPF_ASSERT(a_accept_gives_output, in_accept |=> out_valid_o,
               "accepted request did not reach the output register")
  `RTPF_ASSERT(a_open_gives_header, (in_accept && opens) |=> (out_valid_o && datagram_first_o),
               "fragment opening request did not start with a header byte")
  `RTPF_ASSERT(a_mid_no_header, (in_accept && !opens) |=> (out_valid_o && run_last_o),
               "mid-fragment request produced a header")
  `RTPF_ASSERT_ALWAYS(a_last_is_payload, (out_valid_o && datagram_last_o) |-> run_last_o,
                      "datagram end flagged on a header byte")

endmodule

/* design/rtpf_emit.sv */
// ---------------------------------------------------------------------------
// RTP packetizer output stage
// Holds one job and streams its header bytes and payload byte out.
// ---------------------------------------------------------------------------
module rtpf_emit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  rtpf_pkg::rtpf_job_t job_i,
  output logic              can_load_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [7:0]        out_byte_o,
  output logic              datagram_first_o,
  output logic              datagram_last_o,
  output logic              run_last_o
);
  import rtpf_pkg::*;

  logic      valid_q, valid_d;
  rtpf_idx_t idx_q, idx_d;
  rtpf_job_t job_q;
  logic      is_payload;
  logic      out_fire;

  assign is_payload = (idx_q == PayloadIdx);
  assign out_fire   = valid_q && !out_stall_i;
  assign can_load_o = !valid_q || (out_fire && is_payload);

  always_comb begin
    valid_d = valid_q;
    idx_d   = idx_q;
    if (load_i) begin
      valid_d = 1'b1;
      idx_d   = job_i.has_hdr ? '0 : PayloadIdx;
    end else if (out_fire) begin
      if (is_payload) begin
        valid_d = 1'b0;
      end else begin
        idx_d = idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= PayloadIdx;
    end else begin
      valid_q <= valid_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      job_q <= job_i;
    end
  end

  assign out_valid_o      = valid_q;
  assign out_byte_o       = is_payload ? job_q.data : job_q.hdr[idx_q];
  assign datagram_first_o = (idx_q == '0);
  assign datagram_last_o  = is_payload && job_q.closes;
  assign run_last_o       = is_payload;

endmodule

/* sim/rtp_packetizer_fragmenter_top_tb.sv */
// ---------------------------------------------------------------------------
// RTP packetizer testbench
// Sends payload bytes through the packetizer under random valid gaps and
// output stalls. Every datagram byte is checked against a local model of the
// fragmenter, and the registers are rewritten between phases.
// ---------------------------------------------------------------------------
module rtp_packetizer_fragmenter_top_tb;
  import rtpf_pkg::*;

  // generous bound: ~320 requests, up to 13 bytes each, random stalls on both sides
  localparam int unsigned CycleLimit = 200_000;
  // index that selects no register; a write to it must change nothing
  localparam logic [CfgIdxW-1:0] CfgUnused = 3'd7;
  localparam int unsigned IdlePct = 37;

  // one datagram byte as the output port presents it
  typedef struct packed {
    logic [7:0] data;
    logic       first;
    logic       last;
    logic       run_last;
  } dgram_byte_t;

  logic                clk_i          = 1'b0;
  logic                rst_ni         = 1'b0;
  logic                cfg_valid_i    = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i    = '0;
  logic [31:0]         cfg_data_i     = '0;
  logic                in_valid_i     = 1'b0;
  logic                in_stall_o;
  logic [7:0]          payload_byte_i = '0;
  logic                out_valid_o;
  logic                out_stall_i    = 1'b0;
  logic [7:0]          out_byte_o;
  logic                datagram_first_o;
  logic                datagram_last_o;
  logic                run_last_o;

  rtp_packetizer_fragmenter_top dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .payload_byte_i   (payload_byte_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .out_byte_o       (out_byte_o),
    .datagram_first_o (datagram_first_o),
    .datagram_last_o  (datagram_last_o),
    .run_last_o       (run_last_o)
  );

  always #1 clk_i = ~clk_i;

  // payload bytes waiting to be offered, and datagram bytes still owed by the block
  logic [7:0]  payload_q[$];
  dgram_byte_t expected_datagram_q[$];

  int unsigned n_queued   = 0;
  int unsigned n_accepted = 0;
  int unsigned err_cnt    = 0;
  int unsigned cycles     = 0;

  // no idling on either side while this window of requests goes through
  logic calm;
  assign calm = (n_accepted >= 150) && (n_accepted < 230);

  // shadow registers, kept in step with every completed write
  logic [15:0] cfg_frame_bytes = FrameBytesRst;
  logic [10:0] cfg_max_frag    = MaxFragRst;
  logic [6:0]  cfg_pt          = PayloadTypeRst;
  logic [31:0] cfg_ssrc        = SsrcRst;
  logic [15:0] cfg_samples     = SamplesRst;

  // stream state of the model
  logic [15:0] seq_num     = '0;
  logic [31:0] stream_ts   = '0;
  logic [15:0] frame_off   = '0;
  logic [10:0] frag_cnt    = '0;
  logic [10:0] frag_size   = '0;
  logic        frag_marker = 1'b0;

  // Works out what one accepted payload byte produces. A byte that opens a
  // fragment fixes the fragment's size, marker and the whole header from the
  // registers as they stand at that moment; later bytes only count.
  task automatic rtp_wrap_byte(input logic [7:0] pbyte);
    int unsigned fb;
    int unsigned mp;
    int unsigned remaining;
    logic [7:0]  hdr [HdrLen];
    logic        closes;
    if (frag_cnt == '0) begin
      // a zero size register behaves as one
      fb = (cfg_frame_bytes == '0) ? 1 : cfg_frame_bytes;
      mp = (cfg_max_frag == '0) ? 1 : cfg_max_frag;
      // frame shrunk below what was already sent: one closing byte
      remaining   = (frame_off < fb) ? fb - frame_off : 1;
      frag_size   = (remaining > mp) ? 11'(mp) : 11'(remaining);
      frag_marker = (frag_size == remaining);
      hdr[0]  = VersionByte;
      hdr[1]  = {frag_marker, cfg_pt};
      hdr[2]  = seq_num[15:8];
      hdr[3]  = seq_num[7:0];
      hdr[4]  = stream_ts[31:24];
      hdr[5]  = stream_ts[23:16];
      hdr[6]  = stream_ts[15:8];
      hdr[7]  = stream_ts[7:0];
      hdr[8]  = cfg_ssrc[31:24];
      hdr[9]  = cfg_ssrc[23:16];
      hdr[10] = cfg_ssrc[15:8];
      hdr[11] = cfg_ssrc[7:0];
      for (int i = 0; i < HdrLen; i++) begin
        expected_datagram_q.push_back('{hdr[i], (i == 0), 1'b0, 1'b0});
      end
    end
    frag_cnt  = frag_cnt + 11'd1;
    frame_off = frame_off + 16'd1;
    closes    = (frag_cnt >= frag_size);
    expected_datagram_q.push_back('{pbyte, 1'b0, closes, 1'b1});
    if (closes) begin
      frag_cnt = '0;
      seq_num  = seq_num + 16'd1;
      // timestamp moves on only once the frame's last fragment has gone
      if (frag_marker) begin
        stream_ts = stream_ts + 32'(cfg_samples);
        frame_off = '0;
      end
    end
  endtask

  // Request driver: holds a stalled request, otherwise offers the next byte
  // or idles at random.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i     <= 1'b0;
      payload_byte_i <= '0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        rtp_wrap_byte(payload_byte_i);
        n_accepted <= n_accepted + 1;
      end
      if (in_valid_i && in_stall_o) begin
        // stalled: payload stays put
      end else if (payload_q.size() != 0 && (calm || $urandom_range(99) >= IdlePct)) begin
        in_valid_i     <= 1'b1;
        payload_byte_i <= payload_q.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Datagram monitor: compares each byte taken with the oldest one owed,
  // and stalls the output at random.
  always @(posedge clk_i or negedge rst_ni) begin : dgram_mon
    dgram_byte_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_datagram_q.size() == 0) begin
          $display("%0t: unexpected byte %h (first %b last %b run_last %b)", $time,
                   out_byte_o, datagram_first_o, datagram_last_o, run_last_o);
          err_cnt <= err_cnt + 1;
        end else begin
          want = expected_datagram_q.pop_front();
          if (out_byte_o !== want.data || datagram_first_o !== want.first ||
              datagram_last_o !== want.last || run_last_o !== want.run_last) begin
            $display("%0t: mismatch expected byte %h first %b last %b run_last %b",
                     $time, want.data, want.first, want.last, want.run_last);
            $display("%0t:          actual   byte %h first %b last %b run_last %b",
                     $time, out_byte_o, datagram_first_o, datagram_last_o, run_last_o);
            err_cnt <= err_cnt + 1;
          end
        end
      end
      out_stall_i <= !calm && ($urandom_range(99) < IdlePct);
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("rtp_packetizer_fragmenter_top_tb: done, errors");
      $finish;
    end
  end

  // One register write; the shadow copy follows once the block has taken it.
  task automatic reg_write(input logic [CfgIdxW-1:0] idx, input logic [31:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_FRAME_BYTES:  cfg_frame_bytes = data[15:0];
      CFG_MAX_FRAG:     cfg_max_frag    = data[10:0];
      CFG_PAYLOAD_TYPE: cfg_pt          = data[6:0];
      CFG_SSRC:         cfg_ssrc        = data;
      CFG_SAMPLES:      cfg_samples     = data[15:0];
      default: ;
    endcase
  endtask

  // Waits until every queued request has been accepted and every owed byte
  // has come out.
  task automatic drain();
    while (n_accepted != n_queued || expected_datagram_q.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic queue_byte(input logic [7:0] b);
    payload_q.push_back(b);
    n_queued = n_queued + 1;
  endtask

  task automatic queue_random(input int unsigned n);
    repeat (n) queue_byte(8'($urandom()));
  endtask

  // Random register settings: mostly small frames and fragments so that
  // headers, markers and frame ends come often; now and then the extremes.
  task automatic shuffle_regs();
    logic [15:0] fb;
    logic [10:0] mp;
    logic [15:0] spf;
    case ($urandom_range(9))
      0:       fb = 16'd0;
      1:       fb = 16'hFFFF;
      default: fb = 16'($urandom_range(1, 48));
    endcase
    case ($urandom_range(9))
      0:       mp = 11'd0;
      1:       mp = 11'h7FF;
      2:       mp = 11'd1446;
      default: mp = 11'($urandom_range(1, 12));
    endcase
    case ($urandom_range(4))
      0:       spf = 16'd0;
      1:       spf = 16'hFFFF;
      default: spf = 16'($urandom());
    endcase
    // unused upper data bits carry noise; the block must ignore them
    if ($urandom_range(1)) reg_write(CFG_FRAME_BYTES, {16'($urandom()), fb});
    if ($urandom_range(1)) reg_write(CFG_MAX_FRAG, {21'($urandom()), mp});
    if ($urandom_range(1)) reg_write(CFG_PAYLOAD_TYPE, {25'($urandom()), 7'($urandom())});
    if ($urandom_range(1)) reg_write(CFG_SSRC, $urandom());
    if ($urandom_range(1)) reg_write(CFG_SAMPLES, {16'($urandom()), spf});
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Five-byte frame in fragments of two: marker only on the short last one.
    // All register extremes at the top end, noise in the upper data bits.
    reg_write(CFG_FRAME_BYTES, 32'hFFFF_0005);
    reg_write(CFG_MAX_FRAG, 32'hFFFF_F802);
    reg_write(CFG_PAYLOAD_TYPE, 32'hFFFF_FFFF);
    reg_write(CFG_SSRC, 32'hFFFF_FFFF);
    reg_write(CFG_SAMPLES, 32'hFFFF_FFFF);
    reg_write(CfgUnused, $urandom());
    queue_byte(8'h00);
    queue_byte(8'hFF);
    queue_byte(8'hAA);
    queue_byte(8'h55);
    queue_byte(8'h01);
    drain();

    // zero sizes act as one: each byte a whole marked frame; bottom extremes
    reg_write(CFG_FRAME_BYTES, 32'h0000_0000);
    reg_write(CFG_MAX_FRAG, 32'h0000_0000);
    reg_write(CFG_PAYLOAD_TYPE, 32'h0000_0000);
    reg_write(CFG_SSRC, 32'h0000_0000);
    reg_write(CFG_SAMPLES, 32'h0000_0001);
    queue_random(3);
    drain();

    // ten-byte frame in fours; stop two bytes into the second fragment
    reg_write(CFG_FRAME_BYTES, 32'd10);
    reg_write(CFG_MAX_FRAG, 32'd4);
    reg_write(CFG_SAMPLES, 32'd0);
    queue_random(6);
    drain();

    // Writes with a fragment open: its header and size are already fixed.
    // The frame then sits beyond the new, smaller size, so the next fragment
    // is a single marked byte that closes it.
    reg_write(CFG_FRAME_BYTES, 32'd3);
    reg_write(CFG_PAYLOAD_TYPE, 32'd42);
    reg_write(CFG_SSRC, 32'hA5A5_5A5A);
    reg_write(CFG_SAMPLES, 32'd7);
    queue_random(4);
    drain();

    // random part
    repeat (6) begin
      shuffle_regs();
      queue_random(50);
      drain();
    end

    repeat (16) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("rtp_packetizer_fragmenter_top_tb: done, clean");
    end else begin
      $display("rtp_packetizer_fragmenter_top_tb: done, errors");
    end
    $finish;
  end

endmodule
